// ===== hw/rtl/vn_pkg.sv =====
// shared constants for the vector normalization pipeline
package vn_pkg;

    localparam int COMP_WIDTH  = 16;
    localparam int FRAC_BITS   = 14;
    localparam int LIMIT_WIDTH = 33;
    localparam int LANES       = 4;

    // flag bundle carried down the pipe: lane signs, short vector, zero length
    localparam int FLAG_W     = LANES + 2;
    localparam int FLAG_SHORT = LANES;
    localparam int FLAG_ZERO  = LANES + 1;

endpackage

// ===== hw/rtl/vec4_normalize_top.sv =====
// vec4_normalize_top: four-lane vector normalization to signed Q1.FRAC_BITS
//
// input channel i_in_valid / o_in_ready carries one signed vector per transfer,
// output channel o_out_valid / i_out_ready returns the unit vector and a short
// flag. i_cfg_we writes the squared-length limit from i_cfg_data (reset value 1).
// throughput is one vector per cycle unless the receiver stalls; the pipe is two
// front stages followed by one cell per result bit in the chain.
// each stage holds its item until the next one frees up, so a stalled receiver
// fills the empty slots first and o_in_ready drops only when the whole pipe is
// full. synchronous active-low reset empties the pipe and restores the limit.
// a vector whose squared length is below the limit returns zeros with the flag
// set; a zero vector with a limit of zero returns zeros with the flag clear.
module vec4_normalize_top #(
    parameter int COMP_WIDTH = vn_pkg::COMP_WIDTH,
    parameter int FRAC_BITS  = vn_pkg::FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vn_pkg::LIMIT_WIDTH-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [COMP_WIDTH-1:0]    i_comp_x,
    input  logic signed [COMP_WIDTH-1:0]    i_comp_y,
    input  logic signed [COMP_WIDTH-1:0]    i_comp_z,
    input  logic signed [COMP_WIDTH-1:0]    i_comp_w,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [FRAC_BITS+1:0]     o_unit_x,
    output logic signed [FRAC_BITS+1:0]     o_unit_y,
    output logic signed [FRAC_BITS+1:0]     o_unit_z,
    output logic signed [FRAC_BITS+1:0]     o_unit_w,
    output logic                            o_was_too_short
);
    localparam int SW = 2 * COMP_WIDTH + 1;
    localparam int WW = 2 * COMP_WIDTH + 2 * FRAC_BITS + 3;
    localparam int WP = 2 * COMP_WIDTH + FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int OW = FRAC_BITS + 2;
    localparam int NL = vn_pkg::LANES;
    localparam int NS = QW + 2;

    logic [vn_pkg::LIMIT_WIDTH-1:0] r_limit;
    logic [NS-1:0]                  r_vld;
    logic [NS-1:0]                  w_en;

    logic [NL-1:0][COMP_WIDTH-1:0]  w_comp;
    logic [SW-1:0]                  w_s     [0:QW];
    logic [vn_pkg::FLAG_W-1:0]      w_flags [0:QW];
    logic [NL-1:0][WW-1:0]          w_rem   [0:QW];
    logic [NL-1:0][WP-1:0]          w_p     [0:QW];
    logic [NL-1:0][QW-1:0]          w_q     [0:QW];
    logic [NL-1:0][OW-1:0]          w_unit;
    logic                           w_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= vn_pkg::LIMIT_WIDTH'(1);
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // a stage moves when it is empty or the stage after it moves
    assign w_en[NS-1] = !r_vld[NS-1] || i_out_ready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_comp = {i_comp_w, i_comp_z, i_comp_y, i_comp_x};

    vn_front #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_en_a  (w_en[0]),
        .i_en_b  (w_en[1]),
        .i_limit (r_limit),
        .i_comp  (w_comp),
        .o_s     (w_s[0]),
        .o_flags (w_flags[0]),
        .o_rem   (w_rem[0])
    );

    assign w_p[0] = '0;
    assign w_q[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        vn_cell #(
            .COMP_WIDTH (COMP_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .BIT        (FRAC_BITS - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en[g+2]),
            .i_s     (w_s[g]),
            .i_flags (w_flags[g]),
            .i_rem   (w_rem[g]),
            .i_p     (w_p[g]),
            .i_q     (w_q[g]),
            .o_s     (w_s[g+1]),
            .o_flags (w_flags[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_p     (w_p[g+1]),
            .o_q     (w_q[g+1])
        );
    end

    // short vectors and the zero vector give all-zero lanes
    assign w_mask = w_flags[QW][vn_pkg::FLAG_SHORT] || w_flags[QW][vn_pkg::FLAG_ZERO];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            if (w_mask) begin
                w_unit[l] = '0;
            end else if (w_flags[QW][l]) begin
                w_unit[l] = ~OW'(w_q[QW][l]) + 1'b1;
            end else begin
                w_unit[l] = OW'(w_q[QW][l]);
            end
        end
    end

    assign o_in_ready      = w_en[0];
    assign o_out_valid     = r_vld[NS-1];
    assign o_unit_x        = w_unit[0];
    assign o_unit_y        = w_unit[1];
    assign o_unit_z        = w_unit[2];
    assign o_unit_w        = w_unit[3];
    assign o_was_too_short = w_flags[QW][vn_pkg::FLAG_SHORT];

    a_short_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_was_too_short |->
            o_unit_x == '0 && o_unit_y == '0 && o_unit_z == '0 && o_unit_w == '0)
        else $error("short vector gave nonzero lanes");

    a_ready_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    // a zero squared length leaves the quotient bits meaningless, so only unmasked items
    a_unit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !w_mask |-> w_q[QW][0] <= QW'(1) << FRAC_BITS
            && w_q[QW][1] <= QW'(1) << FRAC_BITS
            && w_q[QW][2] <= QW'(1) << FRAC_BITS
            && w_q[QW][3] <= QW'(1) << FRAC_BITS)
        else $error("unit magnitude above one");

endmodule

// ===== hw/rtl/vn_front.sv =====
// front stages: magnitudes and squares, then squared length and limit compare
module vn_front #(
    parameter int COMP_WIDTH = vn_pkg::COMP_WIDTH,
    parameter int FRAC_BITS  = vn_pkg::FRAC_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_en_a,
    input  logic                                          i_en_b,
    input  logic [vn_pkg::LIMIT_WIDTH-1:0]                i_limit,
    input  logic [vn_pkg::LANES-1:0][COMP_WIDTH-1:0]      i_comp,
    output logic [2*COMP_WIDTH:0]                         o_s,
    output logic [vn_pkg::FLAG_W-1:0]                     o_flags,
    output logic [vn_pkg::LANES-1:0][2*COMP_WIDTH+2*FRAC_BITS+2:0] o_rem
);
    localparam int CW   = COMP_WIDTH;
    localparam int SW   = 2 * CW + 1;
    localparam int WW   = 2 * CW + 2 * FRAC_BITS + 3;
    localparam int CMPW = (SW > vn_pkg::LIMIT_WIDTH) ? SW : vn_pkg::LIMIT_WIDTH;
    localparam int NL   = vn_pkg::LANES;

    logic [NL-1:0][2*CW-1:0] r_sq, n_sq;
    logic [NL-1:0]           r_neg;
    logic [SW-1:0]           r_s, n_s;
    logic [vn_pkg::FLAG_W-1:0] r_flags, n_flags;
    logic [NL-1:0][WW-1:0]   r_rem, n_rem;

    // stage a: magnitude of each lane, most negative value maps to 2^(CW-1)
    always_comb begin
        logic [CW-1:0] mag;
        for (int l = 0; l < NL; l++) begin
            mag      = i_comp[l][CW-1] ? (~i_comp[l] + 1'b1) : i_comp[l];
            n_sq[l]  = (2*CW)'(mag) * (2*CW)'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_sq <= n_sq;
            for (int l = 0; l < NL; l++) begin
                r_neg[l] <= i_comp[l][CW-1];
            end
        end
    end

    // stage b: squared length, compare, initial remainders m^2 << 2F
    always_comb begin
        n_s = '0;
        for (int l = 0; l < NL; l++) begin
            n_s      = n_s + SW'(r_sq[l]);
            n_rem[l] = WW'(r_sq[l]) << (2 * FRAC_BITS);
        end
        n_flags                     = '0;
        n_flags[NL-1:0]             = r_neg;
        n_flags[vn_pkg::FLAG_SHORT] = CMPW'(n_s) < CMPW'(i_limit);
        n_flags[vn_pkg::FLAG_ZERO]  = (n_s == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_s     <= n_s;
            r_flags <= n_flags;
            r_rem   <= n_rem;
        end
    end

    assign o_s     = r_s;
    assign o_flags = r_flags;
    assign o_rem   = r_rem;

endmodule

// ===== hw/rtl/vn_cell.sv =====
// one result bit for all four lanes: trial q|2^b against remainder n - q^2*s
module vn_cell #(
    parameter int COMP_WIDTH = vn_pkg::COMP_WIDTH,
    parameter int FRAC_BITS  = vn_pkg::FRAC_BITS,
    parameter int BIT        = 0
) (
    input  logic                                                    i_clk,
    input  logic                                                    i_en,
    input  logic [2*COMP_WIDTH:0]                                   i_s,
    input  logic [vn_pkg::FLAG_W-1:0]                               i_flags,
    input  logic [vn_pkg::LANES-1:0][2*COMP_WIDTH+2*FRAC_BITS+2:0]  i_rem,
    input  logic [vn_pkg::LANES-1:0][2*COMP_WIDTH+FRAC_BITS+1:0]    i_p,
    input  logic [vn_pkg::LANES-1:0][FRAC_BITS:0]                   i_q,
    output logic [2*COMP_WIDTH:0]                                   o_s,
    output logic [vn_pkg::FLAG_W-1:0]                               o_flags,
    output logic [vn_pkg::LANES-1:0][2*COMP_WIDTH+2*FRAC_BITS+2:0]  o_rem,
    output logic [vn_pkg::LANES-1:0][2*COMP_WIDTH+FRAC_BITS+1:0]    o_p,
    output logic [vn_pkg::LANES-1:0][FRAC_BITS:0]                   o_q
);
    localparam int SW = 2 * COMP_WIDTH + 1;
    localparam int WW = 2 * COMP_WIDTH + 2 * FRAC_BITS + 3;
    localparam int WP = 2 * COMP_WIDTH + FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int NL = vn_pkg::LANES;

    logic [SW-1:0]         r_s;
    logic [vn_pkg::FLAG_W-1:0] r_flags;
    logic [NL-1:0][WW-1:0] r_rem, n_rem;
    logic [NL-1:0][WP-1:0] r_p, n_p;
    logic [NL-1:0][QW-1:0] r_q, n_q;

    // (q + 2^b)^2 s - q^2 s = (q*s) << (b+1) + s << 2b
    always_comb begin
        logic [WW-1:0] trial;
        for (int l = 0; l < NL; l++) begin
            trial = (WW'(i_p[l]) << (BIT + 1)) + (WW'(i_s) << (2 * BIT));
            if (trial <= i_rem[l]) begin
                n_rem[l] = i_rem[l] - trial;
                n_p[l]   = i_p[l] + (WP'(i_s) << BIT);
                n_q[l]   = i_q[l] | (QW'(1) << BIT);
            end else begin
                n_rem[l] = i_rem[l];
                n_p[l]   = i_p[l];
                n_q[l]   = i_q[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s     <= i_s;
            r_flags <= i_flags;
            r_rem   <= n_rem;
            r_p     <= n_p;
            r_q     <= n_q;
        end
    end

    assign o_s     = r_s;
    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_p     = r_p;
    assign o_q     = r_q;

endmodule

// ===== tb/sv/tb_vec4_normalize_top.sv =====
// testbench for vec4_normalize_top: directed and random vectors checked against a predictor
module tb_vec4_normalize_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = vn_pkg::COMP_WIDTH;
    localparam int FB = vn_pkg::FRAC_BITS;
    localparam int LW = vn_pkg::LIMIT_WIDTH;
    localparam int LATENCY = FB + 3;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] w;
    } vec_t;

    typedef struct packed {
        logic signed [FB+1:0] x;
        logic signed [FB+1:0] y;
        logic signed [FB+1:0] z;
        logic signed [FB+1:0] w;
        logic                 short_flag;
    } unit_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [LW-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    vec_t in_vec = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [FB+1:0] o_unit_x, o_unit_y, o_unit_z, o_unit_w;
    logic o_was_too_short;

    vec_t  pending_vecs[$];
    unit_t expected_units[$];
    logic [LW-1:0] length_limit = 1;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  error_count = 0;
    bit  stim_done = 0;

    vec4_normalize_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_comp_x(in_vec.x), .i_comp_y(in_vec.y), .i_comp_z(in_vec.z), .i_comp_w(in_vec.w),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_unit_x(o_unit_x), .o_unit_y(o_unit_y), .o_unit_z(o_unit_z), .o_unit_w(o_unit_w),
        .o_was_too_short(o_was_too_short)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // largest q with q*q*s <= m*m*2^(2*FB), found bit by bit
    function automatic logic [FB+1:0] unit_mag(logic [CW:0] m, logic [LW:0] s);
        logic [FB+1:0] q;
        logic [FB+1:0] cand;
        logic [127:0]  bound;
        bound = ({96'd0, 32'(m) * 32'(m)}) << (2 * FB);
        q = '0;
        for (int b = FB; b >= 0; b--) begin
            cand = q | ((FB+2)'(1) << b);
            if (128'(cand) * 128'(cand) * 128'(s) <= bound) q = cand;
        end
        return q;
    endfunction

    function automatic unit_t normalize_vec(vec_t v, logic [LW-1:0] lim);
        logic [CW:0]   mag[4];
        logic          neg[4];
        logic [LW:0]   s;
        logic [FB+1:0] q[4];
        unit_t r;
        mag[0] = v.x[CW-1] ? -(CW+1)'(v.x) : (CW+1)'(v.x);
        mag[1] = v.y[CW-1] ? -(CW+1)'(v.y) : (CW+1)'(v.y);
        mag[2] = v.z[CW-1] ? -(CW+1)'(v.z) : (CW+1)'(v.z);
        mag[3] = v.w[CW-1] ? -(CW+1)'(v.w) : (CW+1)'(v.w);
        neg[0] = v.x[CW-1]; neg[1] = v.y[CW-1]; neg[2] = v.z[CW-1]; neg[3] = v.w[CW-1];
        s = '0;
        for (int i = 0; i < 4; i++) s += (LW+1)'(mag[i]) * (LW+1)'(mag[i]);
        r = '0;
        if (s < (LW+1)'(lim)) begin
            r.short_flag = 1'b1;
            return r;
        end
        for (int i = 0; i < 4; i++) begin
            q[i] = (s == 0) ? '0 : unit_mag(mag[i], s);
            if (neg[i]) q[i] = -q[i];
        end
        r.x = q[0]; r.y = q[1]; r.z = q[2]; r.w = q[3];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready) begin
                if (pending_vecs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_vec <= pending_vecs[0];
                    expected_units.push_back(normalize_vec(pending_vecs[0], length_limit));
                    void'(pending_vecs.pop_front());
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        unit_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_units.size() == 0) begin
                report_mismatch("unexpected transfer", 0, 0);
            end else begin
                want = expected_units.pop_front();
                if (o_unit_x !== want.x) report_mismatch("unit_x", o_unit_x, want.x);
                if (o_unit_y !== want.y) report_mismatch("unit_y", o_unit_y, want.y);
                if (o_unit_z !== want.z) report_mismatch("unit_z", o_unit_z, want.z);
                if (o_unit_w !== want.w) report_mismatch("unit_w", o_unit_w, want.w);
                if (o_was_too_short !== want.short_flag)
                    report_mismatch("was_too_short", o_was_too_short, want.short_flag);
            end
        end
    end

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return CW'($urandom_range(8)) - 16'd4;
            3: return CW'($urandom_range(512)) - 16'd256;
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic vec_t rand_vec();
        vec_t v;
        v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp(); v.w = rand_comp();
        if ($urandom_range(3) == 0) v.y = '0;
        if ($urandom_range(3) == 0) begin v.z = '0; v.w = '0; end
        return v;
    endfunction

    // waits for the pipe to drain before touching the limit
    task automatic drain_pipe();
        while (pending_vecs.size() > 0 || i_in_valid || expected_units.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LW-1:0] value);
        i_cfg_data <= value;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        length_limit = value;
        @(posedge i_clk);
    endtask

    initial begin
        logic [LW-1:0] limits[6];
        vec_t v;
        limits[0] = 0; limits[1] = 33'h1_0000_0000; limits[2] = 33'd1000;
        limits[3] = 33'h1_ffff_ffff; limits[4] = 33'd2; limits[5] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, with the reset limit of 1
        pending_vecs.push_back('0);
        pending_vecs.push_back({16'h8000, 16'h0, 16'h0, 16'h0});
        pending_vecs.push_back({16'h7fff, 16'h0, 16'h0, 16'h0});
        pending_vecs.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000});
        pending_vecs.push_back({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        pending_vecs.push_back({16'h8000, 16'h7fff, 16'hffff, 16'h0001});
        pending_vecs.push_back({16'h0003, 16'h0004, 16'h0000, 16'h0000});
        pending_vecs.push_back({16'hfffd, 16'h0004, 16'h0000, 16'h0000});
        pending_vecs.push_back({16'h0000, 16'h0000, 16'h0000, 16'hffff});
        pending_vecs.push_back({16'h0001, 16'h0001, 16'h0001, 16'h0001});
        pending_vecs.push_back({16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0});
        drain_pipe();
        write_limit(0);
        pending_vecs.push_back('0);
        pending_vecs.push_back({16'h0001, 16'h0000, 16'h0000, 16'h0000});
        drain_pipe();
        write_limit(33'h1_0000_0000);
        pending_vecs.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000});
        pending_vecs.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8001});
        pending_vecs.push_back({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        drain_pipe();

        for (int phase = 0; phase < 6; phase++) begin
            write_limit(limits[phase]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            for (int n = 0; n < 280; n++) begin
                v = rand_vec();
                if (n % 5 == 0) v = {CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom)};
                pending_vecs.push_back(v);
            end
            drain_pipe();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (error_count == 0 && expected_units.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/vn_pkg.sv
hw/rtl/vn_front.sv
hw/rtl/vn_cell.sv
hw/rtl/vec4_normalize_top.sv
tb/sv/tb_vec4_normalize_top.sv
